FILE: rtl/byte_ring_fifo_defines.svh
// ----------------------------------------------------------------------------
// byte_ring_fifo_defines
// Assertion macros for the byte ring FIFO. Empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_DEFINES_SVH
`define BYTE_RING_FIFO_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset
`define BRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define BRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRF_ASSERT_IMP(lbl, ante, cons, msg)
`define BRF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Operation codes, field widths and the result word of the byte ring FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

  localparam int OP_W   = 2;
  localparam int DATA_W = 8;
  localparam int REQ_W  = 7;
  localparam int LVL_W  = 9;

  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_GET  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
  localparam logic [OP_W-1:0] OP_DROP = 2'd3;

  localparam logic [LVL_W-1:0] TALLY_MAX = 9'd511;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              byte_valid;
    logic              accepted;
    logic [LVL_W-1:0]  done_count;
    logic              last_result;
    logic [LVL_W-1:0]  fill_level;
    logic [LVL_W-1:0]  free_level;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/byte_ring_fifo.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Byte ring buffer: put one byte, get / peek up to a burst, or drop bytes.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------------
//   in_      | input     | in_valid / in_ready | req_type, data_in, put_last,
//            |           |                     | req_length
//   out_     | output    | out_valid/out_ready | data_out, byte_valid, accepted,
//            |           |                     | done_count, last_result,
//            |           |                     | fill_level, free_level
//
// Put, drop and empty get/peek give one word each; the next item is taken
// once the result stage has room. A get or peek of n bytes holds the input
// after it is taken until its last byte is loaded: each byte is one read of
// the store (ST_RD) and one load of the result stage (ST_LD), which waits
// while the result stage is full. Synchronous active-low reset clears the
// pointers, the put tally and all valid flags; the store is not cleared. A
// stalled out_ready holds the result pair and, once full, the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "byte_ring_fifo_defines.svh"

module byte_ring_fifo #(
  parameter int DEPTH     = 256,
  parameter int MAX_BURST = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [brf_pkg::OP_W-1:0]   in_req_type,
  input  wire logic [brf_pkg::DATA_W-1:0] in_data_in,
  input  wire logic                      in_put_last,
  input  wire logic [brf_pkg::REQ_W-1:0]  in_req_length,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [brf_pkg::DATA_W-1:0]      out_data_out,
  output logic                           out_byte_valid,
  output logic                           out_accepted,
  output logic [brf_pkg::LVL_W-1:0]       out_done_count,
  output logic                           out_last_result,
  output logic [brf_pkg::LVL_W-1:0]       out_fill_level,
  output logic [brf_pkg::LVL_W-1:0]       out_free_level
);

  import brf_pkg::*;

  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = IW + 1;
  localparam int CMP_W = (PW > REQ_W) ? PW : REQ_W;
  localparam int BC_W  = (MAX_BURST > 1) ? $clog2(MAX_BURST + 1) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_LD   = 2'd2;

  localparam logic [PW-1:0]    DEPTH_P = PW'(DEPTH);
  localparam logic [CMP_W-1:0] BURST_E = CMP_W'(MAX_BURST);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  logic [1:0]       state_r, state_nxt;
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]    addr_r, addr_nxt;
  logic [LVL_W-1:0] tally_r, tally_nxt;
  logic [BC_W-1:0]  rem_r, rem_nxt;
  logic [BC_W-1:0]  tot_r, tot_nxt;

  res_t pend_r, pend_nxt;
  logic pend_valid_r, pend_valid_nxt;
  res_t out_r;
  logic out_valid_r;

  logic out_free, pend_free, in_acc;
  logic [PW-1:0]    fill_cur, fill_aft, free_aft;
  logic [CMP_W-1:0] req_e, fill_e, lim_e, n_get_e, n_drop_e;
  logic             put_ok;
  logic [LVL_W-1:0] tally_inc;

  assign out_free  = !out_valid_r || out_ready;
  assign pend_free = !pend_valid_r || out_free;
  assign in_ready  = (state_r == ST_IDLE) && pend_free;
  assign in_acc    = in_valid && in_ready;

  assign fill_cur = wr_ptr_r - rd_ptr_r;
  assign fill_aft = wr_ptr_nxt - rd_ptr_nxt;
  assign free_aft = DEPTH_P - fill_aft;

  assign req_e    = CMP_W'(in_req_length);
  assign fill_e   = CMP_W'(fill_cur);
  assign lim_e    = (req_e < BURST_E) ? req_e : BURST_E;
  assign n_get_e  = (lim_e < fill_e) ? lim_e : fill_e;
  assign n_drop_e = (req_e < fill_e) ? req_e : fill_e;

  assign put_ok    = (fill_cur != DEPTH_P);
  assign tally_inc = (tally_r != TALLY_MAX) ? tally_r + 1'b1 : tally_r;

  always_comb begin
    state_nxt      = state_r;
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    addr_nxt       = addr_r;
    tally_nxt      = tally_r;
    rem_nxt        = rem_r;
    tot_nxt        = tot_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r && !out_free;

    pend_nxt.data_out    = '0;
    pend_nxt.byte_valid  = 1'b0;
    pend_nxt.accepted    = 1'b0;
    pend_nxt.done_count  = '0;
    pend_nxt.last_result = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req_type)
            OP_PUT: begin
              if (put_ok) begin
                wr_ptr_nxt = wr_ptr_r + 1'b1;
                pend_nxt.accepted   = 1'b1;
                pend_nxt.done_count = tally_inc;
                tally_nxt           = tally_inc;
              end else begin
                pend_nxt.done_count = tally_r;
              end
              // close the call on its last byte, stored or not
              if (in_put_last) begin
                tally_nxt = '0;
              end
              pend_valid_nxt = 1'b1;
            end
            OP_DROP: begin
              rd_ptr_nxt          = rd_ptr_r + PW'(n_drop_e);
              pend_nxt.done_count = LVL_W'(n_drop_e);
              pend_valid_nxt      = 1'b1;
            end
            OP_GET, OP_PEEK: begin
              if (n_get_e == '0) begin
                pend_valid_nxt = 1'b1;
              end else begin
                addr_nxt  = rd_ptr_r;
                rem_nxt   = BC_W'(n_get_e);
                tot_nxt   = BC_W'(n_get_e);
                state_nxt = ST_RD;
                if (in_req_type == OP_GET) begin
                  rd_ptr_nxt = rd_ptr_r + PW'(n_get_e);
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        addr_nxt  = addr_r + 1'b1;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (pend_free) begin
          pend_nxt.data_out   = rdata_r;
          pend_nxt.byte_valid = 1'b1;
          pend_valid_nxt      = 1'b1;
          rem_nxt             = rem_r - 1'b1;
          if (rem_r == BC_W'(1)) begin
            pend_nxt.done_count = LVL_W'(tot_r);
            state_nxt           = ST_IDLE;
          end else begin
            pend_nxt.last_result = 1'b0;
            state_nxt            = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    pend_nxt.fill_level = LVL_W'(fill_aft);
    pend_nxt.free_level = LVL_W'(free_aft);
    // keep a held word untouched
    if (pend_valid_r && !out_free) begin
      pend_nxt = pend_r;
    end
  end

  // Store: one write port for put, one read port for the burst loop
  always_ff @(posedge clk) begin
    if (in_acc && (in_req_type == OP_PUT) && put_ok) begin
      mem[wr_ptr_r[IW-1:0]] <= in_data_in;
    end
    if (state_r == ST_RD) begin
      rdata_r <= mem[addr_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      tally_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      tally_r      <= tally_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (out_free) begin
        out_valid_r <= pend_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    rem_r  <= rem_nxt;
    tot_r  <= tot_nxt;
    pend_r <= pend_nxt;
    if (out_free && pend_valid_r) begin
      out_r <= pend_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = out_r.data_out;
  assign out_byte_valid  = out_r.byte_valid;
  assign out_accepted    = out_r.accepted;
  assign out_done_count  = out_r.done_count;
  assign out_last_result = out_r.last_result;
  assign out_fill_level  = out_r.fill_level;
  assign out_free_level  = out_r.free_level;

  `BRF_ASSERT_IMP(a_fill_bound, 1'b1, fill_cur <= DEPTH_P, "fill above depth")
  `BRF_ASSERT_NXT(a_no_write_in_burst, state_r != ST_IDLE, $stable(wr_ptr_r), "write during burst")
  `BRF_ASSERT_NXT(a_burst_word, (state_r == ST_LD) && pend_free, pend_valid_r && pend_r.byte_valid, "burst byte lost")
  `BRF_ASSERT_NXT(a_pend_hold, pend_valid_r && !out_free, pend_valid_r, "held word dropped")

endmodule

`default_nettype wire
